### hdl/per_client_token_bucket_limiter_defines.svh
// Assertion macros for the per-client token bucket limiter.
`ifndef PER_CLIENT_TOKEN_BUCKET_LIMITER_DEFINES_SVH
`define PER_CLIENT_TOKEN_BUCKET_LIMITER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define PCTBL_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("limiter check failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define PCTBL_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("limiter check failed");
`else
`define PCTBL_ASSERT_IMP(name, ante, cons)
`define PCTBL_ASSERT_NXT(name, ante, cons)
`endif

`endif

### hdl/pctbl_pkg.sv
// Types and constants of the per-client token bucket limiter.
package pctbl_pkg;

    // One token in bucket units (tokens are kept in 1/60000 token)
    localparam logic [31:0] UNITS_PER_TOKEN = 32'd60000;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_RATE  = 2'd0,
        CFG_BURST = 2'd1,
        CFG_MODE  = 2'd2
    } t_cfg_idx;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PREP = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_ELAP = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_ADD  = 7'b0100000,
        S_TAKE = 7'b1000000
    } t_state;

    // One bucket table entry
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] tokens;
        logic [47:0] last_time;
    } t_entry;

endpackage

### hdl/per_client_token_bucket_limiter.sv
// Per-client token bucket rate limiter: table scan, refill and token take.
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+-----------------------------------
//  request   | start, busy (accept: start&!busy) | i_client_key, i_now_ms
//  result    | o_result_valid (one-cycle strobe) | o_allow, o_entry_claimed, o_entry_index
//  config    | i_cfg_valid, o_cfg_ready       | i_cfg_index, i_cfg_data
//
// A per-client request scans the table, then refills and takes; on a miss it claims a free
// entry or the oldest one. The scan reads one entry per cycle through the single registered
// table read port and stops on a key match; global mode skips the scan and the table.
// A disabled limiter (rate and burst zero) leaves busy low. The result strobe is high in the
// cycle after the accepting edge or in the cycle busy falls; the receiver cannot stall it.
// Reset is synchronous; entries fill in index order, so a fill count stands for valid bits.
`include "per_client_token_bucket_limiter_defines.svh"

module per_client_token_bucket_limiter #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_client_key,
    input  logic [47:0] i_now_ms,
    // result
    output logic        o_result_valid,
    output logic        o_allow,
    output logic        o_entry_claimed,
    output logic [5:0]  o_entry_index,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNTW-1:0] FULL = CNTW'(TABLE_ENTRIES);

    // configuration registers
    logic [15:0] r_rate;
    logic [15:0] r_burst;
    logic        r_mode;

    // sequencer and working registers
    pctbl_pkg::t_state r_state, n_state;
    logic [31:0]     r_key, n_key;
    logic [47:0]     r_now, n_now;
    logic [31:0]     r_cap, n_cap;
    logic [31:0]     r_tok, n_tok;
    logic [47:0]     r_last, n_last;
    logic [31:0]     r_elap, n_elap;
    logic            r_adv, n_adv;
    logic [47:0]     r_prod, n_prod;
    logic [IDXW-1:0] r_idx, n_idx;
    logic            r_claim, n_claim;
    logic            r_new, n_new;
    logic            r_global, n_global;
    logic [CNTW-1:0] r_fill, n_fill;
    logic [CNTW-1:0] r_addr, n_addr;
    logic            r_pend, n_pend;
    logic [IDXW-1:0] r_pidx, n_pidx;
    logic            r_have_old, n_have_old;
    logic [IDXW-1:0] r_old_idx, n_old_idx;
    logic [47:0]     r_old_time, n_old_time;
    logic [31:0]     r_gtok, n_gtok;
    logic [47:0]     r_glast, n_glast;

    // result registers
    logic            r_res_vld, n_res_vld;
    logic            r_res_allow, n_res_allow;
    logic            r_res_claim, n_res_claim;
    logic [IDXW-1:0] r_res_idx, n_res_idx;

    // bucket table
    pctbl_pkg::t_entry r_mem [TABLE_ENTRIES];
    pctbl_pkg::t_entry r_rd_data;

    // datapath helpers
    logic [31:0]     cap_now;
    logic [47:0]     diff;
    logic [48:0]     sum;
    logic            take_ok;
    logic [31:0]     tok_fin;
    logic            accept;
    logic            issue;
    logic [IDXW+5:0] idx_ext;

    assign accept  = start && !busy;
    assign issue   = (r_state == pctbl_pkg::S_SCAN) && (r_addr < r_fill);
    assign cap_now = 32'(r_burst) * pctbl_pkg::UNITS_PER_TOKEN;
    assign diff    = r_now - r_last;
    assign sum     = {17'd0, r_tok} + {1'b0, r_prod};
    assign take_ok = (r_tok >= pctbl_pkg::UNITS_PER_TOKEN);
    assign tok_fin = take_ok ? (r_tok - pctbl_pkg::UNITS_PER_TOKEN) : r_tok;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate  <= 16'd60;
            r_burst <= 16'd10;
            r_mode  <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pctbl_pkg::CFG_RATE:  r_rate  <= i_cfg_data;
                pctbl_pkg::CFG_BURST: r_burst <= i_cfg_data;
                pctbl_pkg::CFG_MODE:  r_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_key      = r_key;
        n_now      = r_now;
        n_cap      = r_cap;
        n_tok      = r_tok;
        n_last     = r_last;
        n_elap     = r_elap;
        n_adv      = r_adv;
        n_prod     = r_prod;
        n_idx      = r_idx;
        n_claim    = r_claim;
        n_new      = r_new;
        n_global   = r_global;
        n_fill     = r_fill;
        n_addr     = r_addr;
        n_pend     = r_pend;
        n_pidx     = r_pidx;
        n_have_old = r_have_old;
        n_old_idx  = r_old_idx;
        n_old_time = r_old_time;
        n_gtok     = r_gtok;
        n_glast    = r_glast;
        n_res_vld  = 1'b0;
        n_res_allow = r_res_allow;
        n_res_claim = r_res_claim;
        n_res_idx   = r_res_idx;

        unique case (r_state)
            pctbl_pkg::S_IDLE: begin
                if (accept) begin
                    n_key      = i_client_key;
                    n_now      = i_now_ms;
                    n_claim    = 1'b0;
                    n_new      = 1'b0;
                    n_idx      = '0;
                    n_addr     = '0;
                    n_pend     = 1'b0;
                    n_have_old = 1'b0;
                    n_old_idx  = '0;
                    n_global   = !r_mode;
                    if (r_rate == 16'd0 && r_burst == 16'd0) begin
                        // limiter off: allow, touch nothing
                        n_res_vld   = 1'b1;
                        n_res_allow = 1'b1;
                        n_res_claim = 1'b0;
                        n_res_idx   = '0;
                    end else begin
                        n_state = pctbl_pkg::S_PREP;
                    end
                end
            end
            pctbl_pkg::S_PREP: begin
                n_cap = cap_now;
                if (!r_global) begin
                    n_state = pctbl_pkg::S_SCAN;
                end else if (r_glast == 48'd0) begin
                    // fresh global bucket
                    n_tok   = cap_now;
                    n_last  = r_now;
                    n_state = pctbl_pkg::S_TAKE;
                end else begin
                    n_tok   = r_gtok;
                    n_last  = r_glast;
                    n_state = pctbl_pkg::S_ELAP;
                end
            end
            pctbl_pkg::S_SCAN: begin
                // read issue, one entry per cycle
                n_pend = issue;
                n_pidx = r_addr[IDXW-1:0];
                if (issue) begin
                    n_addr = r_addr + CNTW'(1);
                end
                if (r_pend && r_rd_data.key == r_key) begin
                    // key hit
                    n_tok   = r_rd_data.tokens;
                    n_last  = r_rd_data.last_time;
                    n_idx   = r_pidx;
                    n_state = pctbl_pkg::S_ELAP;
                end else if (r_pend) begin
                    // track the oldest entry, lowest index wins ties
                    if (!r_have_old || r_rd_data.last_time < r_old_time) begin
                        n_have_old = 1'b1;
                        n_old_idx  = r_pidx;
                        n_old_time = r_rd_data.last_time;
                    end
                end else if (!issue) begin
                    // scan done without a hit: claim free or oldest entry
                    n_claim = 1'b1;
                    n_tok   = r_cap;
                    n_last  = r_now;
                    if (r_fill < FULL) begin
                        n_idx = r_fill[IDXW-1:0];
                        n_new = 1'b1;
                    end else begin
                        n_idx = r_old_idx;
                    end
                    n_state = pctbl_pkg::S_TAKE;
                end
            end
            pctbl_pkg::S_ELAP: begin
                // elapsed time, saturated to 32 bits
                n_adv  = (r_now > r_last);
                n_elap = (diff[47:32] != 16'd0) ? 32'hFFFF_FFFF : diff[31:0];
                n_state = pctbl_pkg::S_MUL;
            end
            pctbl_pkg::S_MUL: begin
                n_prod  = r_elap * r_rate;
                n_state = pctbl_pkg::S_ADD;
            end
            pctbl_pkg::S_ADD: begin
                // refill capped at the burst
                if (r_adv) begin
                    n_tok  = (sum > {17'd0, r_cap}) ? r_cap : sum[31:0];
                    n_last = r_now;
                end
                n_state = pctbl_pkg::S_TAKE;
            end
            pctbl_pkg::S_TAKE: begin
                n_res_vld   = 1'b1;
                n_res_allow = take_ok;
                n_res_claim = r_claim;
                n_res_idx   = r_idx;
                if (r_global) begin
                    n_gtok  = tok_fin;
                    n_glast = r_last;
                end else if (r_new) begin
                    n_fill = r_fill + CNTW'(1);
                end
                n_state = pctbl_pkg::S_IDLE;
            end
            default: begin
                n_state = pctbl_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pctbl_pkg::S_IDLE;
            r_fill    <= '0;
            r_pend    <= 1'b0;
            r_gtok    <= '0;
            r_glast   <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_pend    <= n_pend;
            r_gtok    <= n_gtok;
            r_glast   <= n_glast;
            r_res_vld <= n_res_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_now       <= n_now;
        r_cap       <= n_cap;
        r_tok       <= n_tok;
        r_last      <= n_last;
        r_elap      <= n_elap;
        r_adv       <= n_adv;
        r_prod      <= n_prod;
        r_idx       <= n_idx;
        r_claim     <= n_claim;
        r_new       <= n_new;
        r_global    <= n_global;
        r_addr      <= n_addr;
        r_pidx      <= n_pidx;
        r_have_old  <= n_have_old;
        r_old_idx   <= n_old_idx;
        r_old_time  <= n_old_time;
        r_res_allow <= n_res_allow;
        r_res_claim <= n_res_claim;
        r_res_idx   <= n_res_idx;
    end

    // bucket table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == pctbl_pkg::S_TAKE && !r_global) begin
            r_mem[r_idx] <= '{key: r_key, tokens: tok_fin, last_time: r_last};
        end
        if (issue) begin
            r_rd_data <= r_mem[r_addr[IDXW-1:0]];
        end
    end

    // outputs
    assign idx_ext         = {6'd0, r_res_idx};
    assign busy            = (r_state != pctbl_pkg::S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_result_valid  = r_res_vld;
    assign o_allow         = r_res_allow;
    assign o_entry_claimed = r_res_claim;
    assign o_entry_index   = idx_ext[5:0];

    // checks
    `PCTBL_ASSERT_IMP(a_res_source, o_result_valid,
        $past(start && !busy) || $past(r_state == pctbl_pkg::S_TAKE))
    `PCTBL_ASSERT_NXT(a_take_reports, r_state == pctbl_pkg::S_TAKE, o_result_valid)
    `PCTBL_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= FULL)
    `PCTBL_ASSERT_IMP(a_scan_bound, r_state == pctbl_pkg::S_SCAN, r_addr <= r_fill)

endmodule
